/* hw/rtl/spherical_to_cartesian_state_macros.svh */
// Assertion macros used by the checker file stc_checker.
`ifndef SPHERICAL_TO_CARTESIAN_STATE_MACROS_SVH
`define SPHERICAL_TO_CARTESIAN_STATE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define STC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define STC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Types, constants and the arctangent table of the spherical converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

  localparam int STC_ANGLE_BITS = 16;
  localparam int STC_WORD_BITS  = 32;
  localparam int STC_STEPS      = 30;
  localparam int STC_CW         = 34;  // cordic datapath width

  localparam logic signed [STC_CW-1:0] STC_GAIN = 34'sd652032874;
  localparam logic signed [STC_CW-1:0] STC_ONE  = 34'sd1073741824;

  typedef struct packed {
    logic [30:0]        radius;
    logic [15:0]        azimuth;
    logic [15:0]        polar_angle;
    logic signed [31:0] vel_radial;
    logic signed [31:0] vel_azimuthal;
    logic signed [31:0] vel_polar;
  } stc_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               saturated;
  } stc_out_t;

  // One rotator's working set.
  typedef struct packed {
    logic signed [STC_CW-1:0] x;
    logic signed [STC_CW-1:0] y;
    logic signed [STC_CW-1:0] z;
    logic                     flip;
  } stc_rot_t;

  // Everything that rides down the cell chain.
  typedef struct packed {
    stc_rot_t           phi;
    stc_rot_t           theta;
    logic [30:0]        radius;
    logic signed [31:0] vr;
    logic signed [31:0] vp;
    logic signed [31:0] vt;
  } stc_lane_t;

  function automatic logic signed [STC_CW-1:0] stc_atan(input int step);
    logic [31:0] v;
    case (step)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// stc_cordic_cell
// One CORDIC micro-rotation for both angles; passes the payload along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                adv,
  input  wire                in_valid,
  input  stc_pkg::stc_lane_t in_lane,
  output logic               out_valid_r,
  output stc_pkg::stc_lane_t out_lane_r
);
  import stc_pkg::*;

  localparam logic signed [STC_CW-1:0] ATAN = stc_atan(STEP);

  function automatic stc_rot_t rotate(input stc_rot_t a);
    stc_rot_t o;
    o.flip = a.flip;
    if (a.z >= 0) begin
      o.x = a.x - (a.y >>> STEP);
      o.y = a.y + (a.x >>> STEP);
      o.z = a.z - ATAN;
    end else begin
      o.x = a.x + (a.y >>> STEP);
      o.y = a.y - (a.x >>> STEP);
      o.z = a.z + ATAN;
    end
    return o;
  endfunction

  stc_lane_t lane_nxt;

  always_comb begin
    lane_nxt       = in_lane;
    lane_nxt.phi   = rotate(in_lane.phi);
    lane_nxt.theta = rotate(in_lane.theta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
    if (adv) begin
      out_lane_r <= lane_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stc_combine.sv */
// ----------------------------------------------------------------------------
// stc_combine
// Multiply, sum, round and saturate the sines and cosines into the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_combine #(
  parameter int WORD_BITS = stc_pkg::STC_WORD_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                adv,
  input  wire                in_valid,
  input  stc_pkg::stc_lane_t in_lane,
  output logic               out_valid_r,
  output stc_pkg::stc_out_t  out_data_r
);
  import stc_pkg::*;

  localparam logic signed [65:0] HI  = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] LO  = -(66'sd1 <<< (WORD_BITS - 1));
  localparam logic signed [65:0] HALF = 66'sd1 <<< 29;

  function automatic logic signed [31:0] fin(input stc_rot_t a, input logic use_y);
    logic signed [STC_CW-1:0] v;
    v = use_y ? a.y : a.x;
    if (a.flip) v = -v;
    if (v > STC_ONE) v = STC_ONE;
    if (v < -STC_ONE) v = -STC_ONE;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  function automatic logic signed [65:0] rnd_out(input logic signed [65:0] s);
    return (s + HALF) >>> 30;
  endfunction

  // stage 0: finished sin/cos
  logic               v0_r;
  logic signed [31:0] sp0_r, cp0_r, st0_r, ct0_r;
  logic [30:0]        r0_r;
  logic signed [31:0] vr0_r, vp0_r, vt0_r;
  // stage 1: coefficient products
  logic               v1_r;
  logic signed [63:0] pstcp_r, pstsp_r, pctcp_r, pctsp_r;
  logic signed [31:0] sp1_r, cp1_r, st1_r, ct1_r;
  logic [30:0]        r1_r;
  logic signed [31:0] vr1_r, vp1_r, vt1_r;
  // stage 2: rounded coefficients
  logic               v2_r;
  logic signed [31:0] stcp_r, stsp_r, ctcp_r, ctsp_r;
  logic signed [31:0] sp2_r, cp2_r, st2_r, ct2_r;
  logic [30:0]        r2_r;
  logic signed [31:0] vr2_r, vp2_r, vt2_r;
  // stage 3: operand products
  logic               v3_r;
  logic signed [63:0] px_r, py_r, pz_r;
  logic signed [63:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r;
  // stage 4: sums
  logic               v4_r;
  logic signed [65:0] sx_r, sy_r, sz_r, svx_r, svy_r, svz_r;

  logic signed [65:0] rx, ry, rz, rvx, rvy, rvz;
  logic               hx, hy, hz;
  stc_out_t           out_nxt;

  function automatic logic signed [31:0] clip(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = (v > HI) ? HI : ((v < LO) ? LO : v);
    return c[31:0];
  endfunction

  always_comb begin
    rx  = rnd_out(sx_r);
    ry  = rnd_out(sy_r);
    rz  = rnd_out(sz_r);
    rvx = rnd_out(svx_r);
    rvy = rnd_out(svy_r);
    rvz = rnd_out(svz_r);
    hx  = (rvx > HI) || (rvx < LO);
    hy  = (rvy > HI) || (rvy < LO);
    hz  = (rvz > HI) || (rvz < LO);
    out_nxt.pos_x     = clip(rx);
    out_nxt.pos_y     = clip(ry);
    out_nxt.pos_z     = clip(rz);
    out_nxt.vel_x     = clip(rvx);
    out_nxt.vel_y     = clip(rvy);
    out_nxt.vel_z     = clip(rvz);
    out_nxt.saturated = hx || hy || hz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      v3_r <= 1'b0; v4_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid; v1_r <= v0_r; v2_r <= v1_r;
      v3_r <= v2_r; v4_r <= v3_r; out_valid_r <= v4_r;
    end
    if (adv) begin
      sp0_r <= fin(in_lane.phi, 1'b1);
      cp0_r <= fin(in_lane.phi, 1'b0);
      st0_r <= fin(in_lane.theta, 1'b1);
      ct0_r <= fin(in_lane.theta, 1'b0);
      r0_r  <= in_lane.radius;
      vr0_r <= in_lane.vr; vp0_r <= in_lane.vp; vt0_r <= in_lane.vt;

      pstcp_r <= 64'(st0_r) * 64'(cp0_r);
      pstsp_r <= 64'(st0_r) * 64'(sp0_r);
      pctcp_r <= 64'(ct0_r) * 64'(cp0_r);
      pctsp_r <= 64'(ct0_r) * 64'(sp0_r);
      sp1_r <= sp0_r; cp1_r <= cp0_r; st1_r <= st0_r; ct1_r <= ct0_r;
      r1_r  <= r0_r; vr1_r <= vr0_r; vp1_r <= vp0_r; vt1_r <= vt0_r;

      stcp_r <= rnd30(pstcp_r);
      stsp_r <= rnd30(pstsp_r);
      ctcp_r <= rnd30(pctcp_r);
      ctsp_r <= rnd30(pctsp_r);
      sp2_r <= sp1_r; cp2_r <= cp1_r; st2_r <= st1_r; ct2_r <= ct1_r;
      r2_r  <= r1_r; vr2_r <= vr1_r; vp2_r <= vp1_r; vt2_r <= vt1_r;

      px_r <= 64'($signed({1'b0, r2_r})) * 64'(stcp_r);
      py_r <= 64'($signed({1'b0, r2_r})) * 64'(stsp_r);
      pz_r <= 64'($signed({1'b0, r2_r})) * 64'(ct2_r);
      m0_r <= 64'(stcp_r) * 64'(vr2_r);
      m1_r <= 64'(sp2_r)  * 64'(vp2_r);
      m2_r <= 64'(ctcp_r) * 64'(vt2_r);
      m3_r <= 64'(stsp_r) * 64'(vr2_r);
      m4_r <= 64'(cp2_r)  * 64'(vp2_r);
      m5_r <= 64'(ctsp_r) * 64'(vt2_r);
      m6_r <= 64'(ct2_r)  * 64'(vr2_r);
      m7_r <= 64'(st2_r)  * 64'(vt2_r);

      sx_r  <= 66'(px_r);
      sy_r  <= 66'(py_r);
      sz_r  <= 66'(pz_r);
      svx_r <= 66'(m0_r) - 66'(m1_r) + 66'(m2_r);
      svy_r <= 66'(m3_r) + 66'(m4_r) + 66'(m5_r);
      svz_r <= 66'(m6_r) - 66'(m7_r);

      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/spherical_to_cartesian_state.sv */
// ----------------------------------------------------------------------------
// spherical_to_cartesian_state
// Spherical position and velocity to Cartesian, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled and returns one result per
// request, in order, after a register of angle folding, a chain of 30 CORDIC
// cells (one micro-rotation each, both angles side by side), then six stages
// of 32x32 multiplies, sums, rounding and saturation. The whole pipeline
// moves as one; it holds only while the output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module spherical_to_cartesian_state #(
  parameter int ANGLE_BITS = stc_pkg::STC_ANGLE_BITS,
  parameter int WORD_BITS  = stc_pkg::STC_WORD_BITS
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  stc_pkg::stc_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output stc_pkg::stc_out_t out_data
);
  import stc_pkg::*;

  logic      adv;
  logic      front_valid_r;
  stc_lane_t front_lane_r;
  logic      cell_valid [0:STC_STEPS];
  stc_lane_t cell_lane  [0:STC_STEPS];
  stc_lane_t front_nxt;

  function automatic stc_rot_t fold(input logic [15:0] field);
    stc_rot_t            o;
    logic [31:0]         a;
    logic signed [STC_CW-1:0] z;
    a = (32'(field) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
    z = STC_CW'($signed(a));
    o.flip = 1'b0;
    if (z > STC_ONE) begin
      z = z - (STC_ONE <<< 1);
      o.flip = 1'b1;
    end else if (z < -STC_ONE) begin
      z = z + (STC_ONE <<< 1);
      o.flip = 1'b1;
    end
    o.x = STC_GAIN;
    o.y = '0;
    o.z = z;
    return o;
  endfunction

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    front_nxt.phi    = fold(in_data.azimuth);
    front_nxt.theta  = fold(in_data.polar_angle);
    front_nxt.radius = in_data.radius;
    front_nxt.vr     = in_data.vel_radial;
    front_nxt.vp     = in_data.vel_azimuthal;
    front_nxt.vt     = in_data.vel_polar;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (adv) begin
      front_valid_r <= in_valid;
    end
    if (adv) begin
      front_lane_r <= front_nxt;
    end
  end

  assign cell_valid[0] = front_valid_r;
  assign cell_lane[0]  = front_lane_r;

  for (genvar i = 0; i < STC_STEPS; i++) begin : g_cell
    stc_cordic_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .in_valid   (cell_valid[i]),
      .in_lane    (cell_lane[i]),
      .out_valid_r(cell_valid[i+1]),
      .out_lane_r (cell_lane[i+1])
    );
  end

  stc_combine #(.WORD_BITS(WORD_BITS)) u_combine (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (cell_valid[STC_STEPS]),
    .in_lane    (cell_lane[STC_STEPS]),
    .out_valid_r(out_valid),
    .out_data_r (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/stc_checker.sv */
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the spherical converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_to_cartesian_state_macros.svh"

module stc_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input stc_pkg::stc_out_t out_data
);
  import stc_pkg::*;

  logic sat_edge;

  assign sat_edge = (out_data.vel_x == 32'sh7FFFFFFF) || (out_data.vel_x == 32'sh80000000) ||
                    (out_data.vel_y == 32'sh7FFFFFFF) || (out_data.vel_y == 32'sh80000000) ||
                    (out_data.vel_z == 32'sh7FFFFFFF) || (out_data.vel_z == 32'sh80000000);

  `STC_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid after reset")
  `STC_ASSERT_NOW(a_stall_cause, in_valid && in_stall, out_valid && out_stall,
                  "input held without output stall")
  `STC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data),
                   "stalled result changed")
  `STC_ASSERT_NOW(a_sat_edge, out_valid && out_data.saturated, sat_edge,
                  "saturated without clipped value")

endmodule

bind spherical_to_cartesian_state stc_checker u_stc_checker (.*);

`default_nettype wire
